/* sv/assert_macros.svh */
// Assertion helpers for the transform-matrix block.
// Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ESTM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition in one cycle implies a result in the next one.
`define ESTM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* sv/estm_pkg.sv */
`default_nettype none
package estm_pkg;

    localparam int TRIG_ITERATIONS = 16;
    localparam int MAX_STEPS       = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS > MAX_STEPS) ? MAX_STEPS
                                                                   : TRIG_ITERATIONS;
    // 2^24 / |scale| gives up to 25 quotient bits, one per iteration stage
    localparam int DIV_BITS        = 25;
    localparam int ITER_STAGES     = DIV_BITS;
    // wrap, fold, iterations, trig, products, rotation terms
    localparam int FRONT_STAGES    = ITER_STAGES + 5;

    localparam int QDEPTH = 16;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int ZW = 36;
    localparam int XW = 34;

    typedef logic signed [15:0] ang_t;
    typedef logic signed [15:0] scl_t;
    typedef logic signed [31:0] fix_t;
    typedef logic signed [ZW-1:0] zang_t;
    typedef logic signed [XW-1:0] cval_t;
    typedef logic signed [31:0] trig_t;
    typedef logic signed [32:0] rot_t;
    typedef logic [15:0] rem_t;
    typedef logic [DIV_BITS-1:0] quo_t;

    typedef enum logic {
        OP_MODEL  = 1'b0,
        OP_NORMAL = 1'b1
    } op_t;

    localparam logic [1:0] COL_TRANS  = 2'd3;
    localparam logic [1:0] COL_NORMAL_LAST = 2'd2;

    localparam zang_t Q30_PI      = 36'sd3373259426;
    localparam zang_t Q30_NPI     = -36'sd3373259426;
    localparam zang_t Q30_HALF_PI = 36'sd1686629713;
    localparam zang_t Q30_NHALF_PI = -36'sd1686629713;
    localparam zang_t Q30_TWO_PI  = 36'sd6746518852;
    localparam cval_t CORDIC_GAIN = 34'sd652032874;
    localparam fix_t  ONE_Q16     = 32'sd65536;
    localparam fix_t  FIX_MAX     = 32'sh7FFFFFFF;
    localparam fix_t  FIX_MIN     = 32'sh80000000;

    localparam zang_t ATAN_TAB [MAX_STEPS] = '{
        36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159,
        36'sd67021687, 36'sd33543516, 36'sd16775851, 36'sd8388437,
        36'sd4194283, 36'sd2097149, 36'sd1048576, 36'sd524288,
        36'sd262144, 36'sd131072, 36'sd65536, 36'sd32768,
        36'sd16384, 36'sd8192, 36'sd4096, 36'sd2048,
        36'sd1024, 36'sd512, 36'sd256, 36'sd128
    };

    // One queued matrix: rotation terms [column][row], per-column factor
    typedef struct packed {
        op_t               op;
        logic              zero;
        rot_t [2:0][2:0]   rot;
        fix_t [2:0]        fac;
        fix_t [2:0]        tr;
    } estm_item_t;

    // floor(a * b / 2^30)
    function automatic rot_t mul30(input rot_t a, input rot_t b);
        logic signed [65:0] p;
        p = a * b;
        return p[62:30];
    endfunction

endpackage
`default_nettype wire

/* sv/euler_scale_transform_matrix.sv */
`default_nettype none
// Builds a Y-X-Z (yaw, pitch, roll) rotation matrix with per-axis scale and
// sends it column by column. tuser = 0 gives the 4x4 model matrix (rotation
// columns times scale, then the translation column with 1.0 in row 3, four
// transfers); tuser = 1 gives the 3x3 normal matrix (columns times 1/scale,
// three transfers, a zero scale saturates the reciprocal and sets the flag).
// The output sends one column per cycle unless m_axis_tready stalls it;
// the column sequencer sets the sustained rate. From input transfer to the
// first column transfer an item passes angle wrap and fold, a 25-stage pipe
// that runs the CORDIC steps and the bit-per-stage reciprocal side by side,
// the sin/cos and reciprocal sign stage, two product stages, the queue, and
// two output stages. At most 16 items are in flight (queue depth); the input
// stalls once that many are accepted and their last column has not yet left
// the queue.
module euler_scale_transform_matrix (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // angle_x, angle_y, angle_z, scale_x, scale_y, scale_z, trans_x, trans_y, trans_z
    input  wire logic [191:0] s_axis_tdata,
    // op
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // elem0, elem1, elem2, elem3
    output logic [127:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    // column, zero_scale
    output logic [2:0]        m_axis_tuser
);
    import estm_pkg::*;

    `include "assert_macros.svh"

    ang_t [2:0]  ang;
    scl_t [2:0]  sc;
    fix_t [2:0]  tr;
    fix_t [3:0]  elem;
    op_t         op;
    logic        accept, pop, f_vld, q_vld, out_zero;
    logic [1:0]  out_col;
    estm_item_t  f_item, q_item;
    logic [QCNT_W-1:0] q_count;
    // items accepted and not yet fully sent into the back end
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // lanes ordered as the rotation uses them: yaw (s1 c1), pitch, roll
    assign ang[0] = s_axis_tdata[31:16];
    assign ang[1] = s_axis_tdata[15:0];
    assign ang[2] = s_axis_tdata[47:32];
    assign sc[0]  = s_axis_tdata[63:48];
    assign sc[1]  = s_axis_tdata[79:64];
    assign sc[2]  = s_axis_tdata[95:80];
    assign tr[0]  = s_axis_tdata[127:96];
    assign tr[1]  = s_axis_tdata[159:128];
    assign tr[2]  = s_axis_tdata[191:160];
    assign op     = op_t'(s_axis_tuser);

    // credit guard: every accepted item has a queue slot waiting
    assign s_axis_tready = (cnt_reg < QCNT_W'(QDEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cnt_next      = cnt_reg + QCNT_W'(accept) - QCNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    estm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (accept),
        .in_op    (op),
        .in_ang   (ang),
        .in_sc    (sc),
        .in_tr    (tr),
        .out_vld  (f_vld),
        .out_item (f_item)
    );

    estm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_vld),
        .wr_item (f_item),
        .rd      (pop),
        .rd_vld  (q_vld),
        .rd_item (q_item),
        .count   (q_count)
    );

    estm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_vld    (q_vld),
        .q_item   (q_item),
        .pop      (pop),
        .out_vld  (m_axis_tvalid),
        .out_rdy  (m_axis_tready),
        .out_col  (out_col),
        .out_elem (elem),
        .out_last (m_axis_tlast),
        .out_zero (out_zero)
    );

    assign m_axis_tdata = elem;
    assign m_axis_tuser = {out_zero, out_col};

    // queued items are a subset of the credited ones
    `ESTM_ASSERT(a_queue_in_credit, q_count <= cnt_reg, "queue holds more than credited")
    // a transfer accepted with no pop raises the credit count by one
    `ESTM_ASSERT_NEXT(a_credit_step, accept && !pop, cnt_reg == $past(cnt_reg) + 1'b1, "credit count slip")
    // zero-scale flag only appears on normal-mode columns
    `ESTM_ASSERT(a_zero_normal, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata[127:96] == 32'd0 && m_axis_tuser[1:0] != COL_TRANS, "zero flag outside normal mode")
    // last marks the final column of either matrix shape
    `ESTM_ASSERT(a_last_col, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == COL_TRANS || m_axis_tuser[1:0] == COL_NORMAL_LAST, "last on wrong column")

endmodule
`default_nettype wire

/* sv/estm_front.sv */
`default_nettype none
module estm_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_vld,
    input  wire estm_pkg::op_t          in_op,
    input  wire estm_pkg::ang_t [2:0]   in_ang,   // yaw, pitch, roll
    input  wire estm_pkg::scl_t [2:0]   in_sc,
    input  wire estm_pkg::fix_t [2:0]   in_tr,
    output logic                        out_vld,
    output estm_pkg::estm_item_t        out_item
);
    import estm_pkg::*;

    typedef struct packed {
        op_t         op;
        zang_t [2:0] z;
        scl_t  [2:0] sc;
        fix_t  [2:0] tr;
    } wrap_t;

    typedef struct packed {
        op_t             op;
        zang_t [2:0]     z;
        cval_t [2:0]     x;
        cval_t [2:0]     y;
        logic  [2:0]     flip;
        scl_t  [2:0]     sc;
        fix_t  [2:0]     tr;
        logic  [2:0][15:0] mag;
        rem_t  [2:0]     rem;
        quo_t  [2:0]     quo;
    } iter_t;

    typedef struct packed {
        op_t         op;
        logic        zero;
        trig_t [2:0] s;
        trig_t [2:0] c;
        fix_t  [2:0] fac;
        fix_t  [2:0] tr;
    } trig_stage_t;

    typedef struct packed {
        op_t        op;
        logic       zero;
        rot_t       c1c3, s1s2, c2s3, c1s2, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
        rot_t       s2, s3;
        fix_t [2:0] fac;
        fix_t [2:0] tr;
    } prod_t;

    logic [FRONT_STAGES-1:0] vld_reg;
    wrap_t       w_reg, w_next;
    iter_t       st_reg [ITER_STAGES+1];
    iter_t       f_next;
    trig_stage_t t_reg, t_next;
    prod_t       p_reg, p_next;
    estm_item_t  o_reg, o_next;
    zang_t [2:0] z_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_vld};
    end
    assign out_vld  = vld_reg[FRONT_STAGES-1];
    assign out_item = o_reg;

    // angle to Q.30, wrapped into [-pi, pi]
    always_comb
    begin
        w_next.op = in_op;
        w_next.sc = in_sc;
        w_next.tr = in_tr;
        for (int i = 0; i < 3; i++)
        begin
            z_in[i] = {{2{in_ang[i][15]}}, in_ang[i], 18'd0};
            if (z_in[i] > Q30_PI)
                w_next.z[i] = z_in[i] - Q30_TWO_PI;
            else if (z_in[i] < Q30_NPI)
                w_next.z[i] = z_in[i] + Q30_TWO_PI;
            else
                w_next.z[i] = z_in[i];
        end
    end

    // fold into [-pi/2, pi/2]; cosine sign flips when folded
    always_comb
    begin
        f_next.op = w_reg.op;
        f_next.sc = w_reg.sc;
        f_next.tr = w_reg.tr;
        for (int i = 0; i < 3; i++)
        begin
            f_next.x[i] = CORDIC_GAIN;
            f_next.y[i] = '0;
            if (w_reg.z[i] > Q30_HALF_PI)
            begin
                f_next.z[i]    = Q30_PI - w_reg.z[i];
                f_next.flip[i] = 1'b1;
            end
            else if (w_reg.z[i] < Q30_NHALF_PI)
            begin
                f_next.z[i]    = Q30_NPI - w_reg.z[i];
                f_next.flip[i] = 1'b1;
            end
            else
            begin
                f_next.z[i]    = w_reg.z[i];
                f_next.flip[i] = 1'b0;
            end
            f_next.mag[i] = w_reg.sc[i][15] ? (~w_reg.sc[i] + 16'd1) : w_reg.sc[i];
            f_next.rem[i] = '0;
            f_next.quo[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg     <= w_next;
        st_reg[0] <= f_next;
    end

    // each stage: one quotient bit per lane, plus one CORDIC micro-rotation in the first CORDIC_STEPS stages
    for (genvar k = 0; k < ITER_STAGES; k++)
    begin : g_iter
        iter_t            nx;
        logic [2:0][16:0] rs;

        always_comb
        begin
            nx = st_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (k < CORDIC_STEPS)
                begin
                    if (!st_reg[k].z[i][ZW-1])
                    begin
                        nx.x[i] = $signed(st_reg[k].x[i]) - ($signed(st_reg[k].y[i]) >>> k);
                        nx.y[i] = $signed(st_reg[k].y[i]) + ($signed(st_reg[k].x[i]) >>> k);
                        nx.z[i] = $signed(st_reg[k].z[i]) - ATAN_TAB[k % MAX_STEPS];
                    end
                    else
                    begin
                        nx.x[i] = $signed(st_reg[k].x[i]) + ($signed(st_reg[k].y[i]) >>> k);
                        nx.y[i] = $signed(st_reg[k].y[i]) - ($signed(st_reg[k].x[i]) >>> k);
                        nx.z[i] = $signed(st_reg[k].z[i]) + ATAN_TAB[k % MAX_STEPS];
                    end
                end
                // dividend 2^24 has its only set bit at the first step
                rs[i] = {st_reg[k].rem[i], (k == 0) ? 1'b1 : 1'b0};
                if (rs[i] >= {1'b0, st_reg[k].mag[i]})
                begin
                    nx.rem[i] = 16'(rs[i] - {1'b0, st_reg[k].mag[i]});
                    nx.quo[i] = {st_reg[k].quo[i][DIV_BITS-2:0], 1'b1};
                end
                else
                begin
                    nx.rem[i] = rs[i][15:0];
                    nx.quo[i] = {st_reg[k].quo[i][DIV_BITS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            st_reg[k+1] <= nx;
        end
    end

    // sin/cos, reciprocal sign and saturation, column factor
    always_comb
    begin
        logic signed [DIV_BITS:0] qs;
        cval_t                    cx;
        t_next.op   = st_reg[ITER_STAGES].op;
        t_next.tr   = st_reg[ITER_STAGES].tr;
        t_next.zero = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            t_next.s[i] = st_reg[ITER_STAGES].y[i][31:0];
            cx = st_reg[ITER_STAGES].flip[i] ? -$signed(st_reg[ITER_STAGES].x[i])
                                              : $signed(st_reg[ITER_STAGES].x[i]);
            t_next.c[i] = cx[31:0];
            qs = st_reg[ITER_STAGES].sc[i][15]
               ? -$signed({1'b0, st_reg[ITER_STAGES].quo[i]})
               : $signed({1'b0, st_reg[ITER_STAGES].quo[i]});
            if (st_reg[ITER_STAGES].op == OP_NORMAL)
            begin
                if (st_reg[ITER_STAGES].sc[i] == '0)
                begin
                    t_next.fac[i] = FIX_MAX;
                    t_next.zero   = 1'b1;
                end
                else
                    t_next.fac[i] = 32'(qs);
            end
            else
                t_next.fac[i] = 32'($signed(st_reg[ITER_STAGES].sc[i]));
        end
    end

    // first-level products (lane 0 yaw: s1 c1, lane 1 pitch: s2 c2, lane 2 roll: s3 c3)
    always_comb
    begin
        p_next.op   = t_reg.op;
        p_next.zero = t_reg.zero;
        p_next.fac  = t_reg.fac;
        p_next.tr   = t_reg.tr;
        p_next.s2   = rot_t'($signed(t_reg.s[1]));
        p_next.s3   = rot_t'($signed(t_reg.s[2]));
        p_next.c1c3 = mul30(rot_t'($signed(t_reg.c[0])), rot_t'($signed(t_reg.c[2])));
        p_next.s1s2 = mul30(rot_t'($signed(t_reg.s[0])), rot_t'($signed(t_reg.s[1])));
        p_next.c2s3 = mul30(rot_t'($signed(t_reg.c[1])), rot_t'($signed(t_reg.s[2])));
        p_next.c1s2 = mul30(rot_t'($signed(t_reg.c[0])), rot_t'($signed(t_reg.s[1])));
        p_next.c3s1 = mul30(rot_t'($signed(t_reg.c[2])), rot_t'($signed(t_reg.s[0])));
        p_next.c1s3 = mul30(rot_t'($signed(t_reg.c[0])), rot_t'($signed(t_reg.s[2])));
        p_next.c2c3 = mul30(rot_t'($signed(t_reg.c[1])), rot_t'($signed(t_reg.c[2])));
        p_next.s1s3 = mul30(rot_t'($signed(t_reg.s[0])), rot_t'($signed(t_reg.s[2])));
        p_next.c2s1 = mul30(rot_t'($signed(t_reg.c[1])), rot_t'($signed(t_reg.s[0])));
        p_next.c1c2 = mul30(rot_t'($signed(t_reg.c[0])), rot_t'($signed(t_reg.c[1])));
    end

    // triple products and rotation terms
    always_comb
    begin
        o_next.op   = p_reg.op;
        o_next.zero = p_reg.zero;
        o_next.fac  = p_reg.fac;
        o_next.tr   = p_reg.tr;
        o_next.rot[0][0] = p_reg.c1c3 + mul30(p_reg.s1s2, p_reg.s3);
        o_next.rot[0][1] = p_reg.c2s3;
        o_next.rot[0][2] = mul30(p_reg.c1s2, p_reg.s3) - p_reg.c3s1;
        o_next.rot[1][0] = mul30(p_reg.c3s1, p_reg.s2) - p_reg.c1s3;
        o_next.rot[1][1] = p_reg.c2c3;
        o_next.rot[1][2] = mul30(p_reg.c1c3, p_reg.s2) + p_reg.s1s3;
        o_next.rot[2][0] = p_reg.c2s1;
        o_next.rot[2][1] = -p_reg.s2;
        o_next.rot[2][2] = p_reg.c1c2;
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next;
        p_reg <= p_next;
        o_reg <= o_next;
    end

endmodule
`default_nettype wire

/* sv/estm_queue.sv */
`default_nettype none
module estm_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr,
    input  wire estm_pkg::estm_item_t          wr_item,
    input  wire logic                          rd,
    output logic                               rd_vld,
    output estm_pkg::estm_item_t               rd_item,
    output logic [estm_pkg::QCNT_W-1:0]        count
);
    import estm_pkg::*;

    estm_item_t        mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wp_next  = wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = rd ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + QCNT_W'(wr) - QCNT_W'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_item;
    end

    assign rd_vld  = (cnt_reg != '0);
    assign rd_item = mem_reg[rp_reg];
    assign count   = cnt_reg;

endmodule
`default_nettype wire

/* sv/estm_back.sv */
`default_nettype none
module estm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_vld,
    input  wire estm_pkg::estm_item_t q_item,
    output logic                      pop,
    output logic                      out_vld,
    input  wire logic                 out_rdy,
    output logic [1:0]                out_col,
    output estm_pkg::fix_t [3:0]      out_elem,
    output logic                      out_last,
    output logic                      out_zero
);
    import estm_pkg::*;

    typedef struct packed {
        logic [1:0]              col;
        logic                    last;
        logic                    zero;
        op_t                     op;
        logic                    trans;
        logic [2:0][64:0]        prod;
        fix_t [2:0]              tr;
    } mstage_t;

    logic [1:0] col_reg, col_next;
    logic       m_vld_reg, m_vld_next;
    logic       o_vld_reg, o_vld_next;
    mstage_t    m_reg, m_next;
    fix_t [3:0] elem_reg, elem_next;
    logic [1:0] ocol_reg;
    logic       olast_reg, ozero_reg;
    logic       o_load, m_load, take, last_col;
    logic [1:0] csel;
    logic signed [64:0] sh [3];

    assign o_load   = !o_vld_reg || out_rdy;
    assign m_load   = !m_vld_reg || o_load;
    assign take     = q_vld && m_load;
    assign last_col = (q_item.op == OP_NORMAL) ? (col_reg == COL_NORMAL_LAST)
                                               : (col_reg == COL_TRANS);
    assign pop      = take && last_col;
    assign csel     = (col_reg == COL_TRANS) ? 2'd0 : col_reg;

    always_comb
    begin
        col_next   = take ? (last_col ? 2'd0 : col_reg + 2'd1) : col_reg;
        m_vld_next = m_load ? q_vld : m_vld_reg;
        o_vld_next = o_load ? m_vld_reg : o_vld_reg;

        m_next.col   = col_reg;
        m_next.last  = last_col;
        m_next.zero  = q_item.zero;
        m_next.op    = q_item.op;
        m_next.trans = (q_item.op == OP_MODEL) && (col_reg == COL_TRANS);
        m_next.tr    = q_item.tr;
        for (int r = 0; r < 3; r++)
            m_next.prod[r] = $signed(q_item.rot[csel][r]) * $signed(q_item.fac[csel]);

        for (int r = 0; r < 3; r++)
        begin
            sh[r] = (m_reg.op == OP_NORMAL) ? ($signed(m_reg.prod[r]) >>> 30)
                                            : ($signed(m_reg.prod[r]) >>> 22);
            if (m_reg.trans)
                elem_next[r] = m_reg.tr[r];
            else if (sh[r] > 65'sd2147483647)
                elem_next[r] = FIX_MAX;
            else if (sh[r] < -65'sd2147483648)
                elem_next[r] = FIX_MIN;
            else
                elem_next[r] = sh[r][31:0];
        end
        elem_next[3] = m_reg.trans ? ONE_Q16 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            m_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            m_vld_reg <= m_vld_next;
            o_vld_reg <= o_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
            m_reg <= m_next;
        if (o_load)
        begin
            elem_reg  <= elem_next;
            ocol_reg  <= m_reg.col;
            olast_reg <= m_reg.last;
            ozero_reg <= m_reg.zero;
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_col  = ocol_reg;
    assign out_elem = elem_reg;
    assign out_last = olast_reg;
    assign out_zero = ozero_reg;

endmodule
`default_nettype wire
